FILE: hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// shared widths, codes, cell control types and helpers for the block cache
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int MAX_RUN_DEF = 16;

    localparam int TAG_W  = 32;
    localparam int RUN_W  = 5;
    localparam int CFG_W  = 7;
    localparam int SLOT_W = 6;
    localparam int MISS_W = 5;
    localparam int CNT_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

    // request kind codes
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic look;      // compare stored tag against the broadcast block
        logic upd_hit;   // apply a hit update
        logic upd_miss;  // apply a miss update (fill and token move)
        logic wr;        // request is a write
    } cell_cmd_t;

    // what a cell reports back
    typedef struct packed {
        logic match;     // registered tag match among entries in use
        logic tok_act;   // holds the insert token and is in use
        logic valid;
        logic dirty;
    } cell_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

FILE: hdl/fbc_cell.sv
// ----------------------------------------------------------------------------
// fbc_cell
// one cache entry: tag, valid, dirty, match flag and insert token
// ----------------------------------------------------------------------------
module fbc_cell
    import fbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX     = 0,
    localparam int CW     = $clog2(ENTRIES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [TAG_W-1:0] blk,
    input  logic [CW-1:0]    n,
    input  logic             sel_hit,
    input  logic             take,
    input  logic             token_in,
    output cell_stat_t       stat,
    output logic [TAG_W-1:0] tag,
    output logic             pass_out,
    output logic             wrap_out
);

    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [CW:0]   NEXT_IDX = (CW + 1)'(IDX + 1);
    localparam logic          TOK_INIT = (IDX == 0);

    logic [TAG_W-1:0] tag_reg;
    logic             valid_reg;
    logic             dirty_reg;
    logic             tok_reg;
    logic             match_reg;
    logic             in_use;
    logic             is_last;

    assign in_use  = MY_IDX < n;
    assign is_last = NEXT_IDX >= {1'b0, n};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            tok_reg   <= TOK_INIT;
            match_reg <= 1'b0;
        end
        else
        begin
            if (cmd.look)
            begin
                match_reg <= valid_reg & in_use & (tag_reg == blk);
            end
            if (cmd.upd_hit && sel_hit && cmd.wr)
            begin
                dirty_reg <= 1'b1;
            end
            if (cmd.upd_miss)
            begin
                tok_reg <= token_in;
                if (take)
                begin
                    valid_reg <= 1'b1;
                    dirty_reg <= cmd.wr;
                end
            end
        end
    end

    // tag storage, meaningful only once valid
    always_ff @(posedge clk)
    begin
        if (cmd.upd_miss && take)
        begin
            tag_reg <= blk;
        end
    end

    // token goes to the neighbor, or back to entry 0 from the last entry in use
    assign pass_out = take & ~is_last;
    assign wrap_out = take & is_last;

    assign stat.match   = match_reg;
    assign stat.tok_act = tok_reg & in_use;
    assign stat.valid   = valid_reg;
    assign stat.dirty   = dirty_reg;
    assign tag          = tag_reg;

endmodule

FILE: hdl/fifo_replacement_block_cache.sv
// ----------------------------------------------------------------------------
// fifo_replacement_block_cache
// fully associative write-back block cache with fifo replacement
// ----------------------------------------------------------------------------
// sequencing: each block of a run gets a compare step, then an update step, on the chain
//   of entry cells; the update registers the block's result beat and waits while a
//   result beat is held by a stall; the request input stays stalled from the request
//   beat until the whole run, at most 16 blocks, is done
// reset: valid and dirty maps, insert token (at entry 0) and totals cleared at once,
//   entries_in_use back to 64; tags are not reset, they are only read once valid
module fifo_replacement_block_cache
    import fbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration
    input  logic              cfg_write_en,
    input  logic [CFG_W-1:0]  cfg_write_data,

    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [TAG_W-1:0]  start_block,
    input  logic [RUN_W-1:0]  run_length,
    input  logic              kind,

    // result channel
    output logic              res_valid,
    input  logic              res_stall,
    output logic [TAG_W-1:0]  block_address,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              replaced,
    output logic              writeback_needed,
    output logic [TAG_W-1:0]  victim_block,
    output logic              last,
    output logic [MISS_W-1:0] request_misses,
    output logic [CNT_W-1:0]  total_hits,
    output logic [CNT_W-1:0]  total_misses,
    output logic [CNT_W-1:0]  total_replacements
);

    localparam int CW = $clog2(ENTRIES + 1);           // holds the count of entries
    localparam int IW = $clog2(ENTRIES);               // entry index
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;     // common width for clamping
    localparam int RW = $clog2(MAX_RUN + 1);           // block counter
    localparam int LW = (RW > RUN_W) ? RW : RUN_W;     // common width for run clamp

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        state_reg;
    logic [CFG_W-1:0]  ent_reg;
    logic [TAG_W-1:0]  blk_reg;
    logic [RW-1:0]     len_reg;
    logic [RW-1:0]     k_reg;
    logic [RW-1:0]     miss_run_reg;
    logic              wr_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic [CNT_W-1:0]  repl_cnt_reg;
    logic              res_valid_reg;

    // -------------------------------------------------------------------------
    // entries in use, clamped to 1..ENTRIES
    // -------------------------------------------------------------------------
    logic [NW-1:0] ent_w;
    logic [NW-1:0] n_w;
    logic [CW-1:0] n;

    always_comb
    begin
        ent_w = NW'(ent_reg);
        if (ent_w == '0)
        begin
            n_w = NW'(1);
        end
        else if (ent_w > NW'(ENTRIES))
        begin
            n_w = NW'(ENTRIES);
        end
        else
        begin
            n_w = ent_w;
        end
        n = CW'(n_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            ent_reg <= cfg_write_data;
        end
    end

    // -------------------------------------------------------------------------
    // chain of entry cells
    // -------------------------------------------------------------------------
    cell_cmd_t        cmd;
    cell_stat_t       stat_vec [ENTRIES];
    logic [TAG_W-1:0] tag_vec  [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] tok_vec;
    logic [ENTRIES-1:0] hit_sel;
    logic [ENTRIES-1:0] take_vec;
    logic [ENTRIES-1:0] pass_vec;
    logic [ENTRIES-1:0] wrap_vec;
    logic               fire;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic token_in;

        if (g == 0)
        begin : g_head
            assign token_in = |wrap_vec;          // wrap from the last entry in use
        end
        else
        begin : g_body
            assign token_in = pass_vec[g-1];      // handed on by the lower neighbor
        end

        fbc_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .blk      (blk_reg),
            .n        (n),
            .sel_hit  (hit_sel[g]),
            .take     (take_vec[g]),
            .token_in (token_in),
            .stat     (stat_vec[g]),
            .tag      (tag_vec[g]),
            .pass_out (pass_vec[g]),
            .wrap_out (wrap_vec[g])
        );

        assign match_vec[g] = stat_vec[g].match;
        assign tok_vec[g]   = stat_vec[g].tok_act;
    end

    // lowest matching entry wins
    logic any_hit;
    assign any_hit = |match_vec;
    assign hit_sel = match_vec & (~match_vec + ENTRIES'(1));

    // token outside the entries in use falls back to entry 0
    assign take_vec = (|tok_vec) ? tok_vec : ENTRIES'(1);

    assign cmd.look     = (state_reg == ST_LOOK);
    assign cmd.upd_hit  = fire & any_hit;
    assign cmd.upd_miss = fire & ~any_hit;
    assign cmd.wr       = (wr_reg == KIND_WRITE);

    // -------------------------------------------------------------------------
    // read out the selected entry (one-hot select, or-reduced)
    // -------------------------------------------------------------------------
    logic [ENTRIES-1:0] sel_vec;
    logic [IW-1:0]      sel_idx;
    logic [TAG_W-1:0]   take_tag;
    logic               take_valid;
    logic               take_dirty;

    assign sel_vec = any_hit ? hit_sel : take_vec;

    always_comb
    begin
        sel_idx    = '0;
        take_tag   = '0;
        take_valid = 1'b0;
        take_dirty = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sel_idx    = sel_idx    | (sel_vec[i]  ? IW'(i)     : '0);
            take_tag   = take_tag   | (take_vec[i] ? tag_vec[i] : '0);
            take_valid = take_valid | (take_vec[i] & stat_vec[i].valid);
            take_dirty = take_dirty | (take_vec[i] & stat_vec[i].dirty);
        end
    end

    // -------------------------------------------------------------------------
    // result of the block in the update cycle
    // -------------------------------------------------------------------------
    logic                 evict;
    logic [CNT_W-1:0]     hit_cnt_next;
    logic [CNT_W-1:0]     miss_cnt_next;
    logic [CNT_W-1:0]     repl_cnt_next;
    logic [RW-1:0]        miss_run_next;
    logic                 last_blk;
    logic [SLOT_W+IW-1:0] slot_wide;
    logic [MISS_W+RW-1:0] miss_wide;

    assign evict         = ~any_hit & take_valid;
    assign hit_cnt_next  = any_hit ? sat_inc(hit_cnt_reg)  : hit_cnt_reg;
    assign miss_cnt_next = any_hit ? miss_cnt_reg : sat_inc(miss_cnt_reg);
    assign repl_cnt_next = evict   ? sat_inc(repl_cnt_reg) : repl_cnt_reg;
    assign miss_run_next = any_hit ? miss_run_reg : miss_run_reg + RW'(1);
    assign last_blk      = ({1'b0, k_reg} + (RW + 1)'(1)) == {1'b0, len_reg};
    assign slot_wide     = {{SLOT_W{1'b0}}, sel_idx};
    assign miss_wide     = {{MISS_W{1'b0}}, miss_run_next};

    // the update waits while a result beat is held by a stall
    assign fire = (state_reg == ST_UPD) & (~res_valid_reg | ~res_stall);

    // -------------------------------------------------------------------------
    // request intake and sequencing
    // -------------------------------------------------------------------------
    logic          req_take;
    logic [LW-1:0] run_w;
    logic [LW-1:0] len_w;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid & ~req_stall;
    assign run_w     = LW'(run_length);
    assign len_w     = (run_w > LW'(MAX_RUN)) ? LW'(MAX_RUN) : run_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            k_reg        <= '0;
            miss_run_reg <= '0;
            wr_reg       <= KIND_READ;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            repl_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        len_reg      <= RW'(len_w);
                        k_reg        <= '0;
                        miss_run_reg <= '0;
                        wr_reg       <= kind;
                        // an empty run gives no beats
                        if (len_w != '0)
                        begin
                            state_reg <= ST_LOOK;
                        end
                    end
                end
                ST_LOOK:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (fire)
                    begin
                        hit_cnt_reg  <= hit_cnt_next;
                        miss_cnt_reg <= miss_cnt_next;
                        repl_cnt_reg <= repl_cnt_next;
                        miss_run_reg <= miss_run_next;
                        k_reg        <= k_reg + RW'(1);
                        state_reg    <= last_blk ? ST_IDLE : ST_LOOK;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // block number walks through the run, wrapping modulo 2^32
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            blk_reg <= start_block;
        end
        else if (fire)
        begin
            blk_reg <= blk_reg + TAG_W'(1);
        end
    end

    // -------------------------------------------------------------------------
    // result register, freed as soon as its beat is taken
    // -------------------------------------------------------------------------
    logic [TAG_W-1:0]  blk_out_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              repl_reg;
    logic              wb_reg;
    logic [TAG_W-1:0]  victim_reg;
    logic              last_reg;
    logic [MISS_W-1:0] req_miss_reg;
    logic [CNT_W-1:0]  tot_hit_reg;
    logic [CNT_W-1:0]  tot_miss_reg;
    logic [CNT_W-1:0]  tot_repl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            blk_out_reg  <= blk_reg;
            hit_reg      <= any_hit;
            slot_reg     <= slot_wide[SLOT_W-1:0];
            repl_reg     <= evict;
            wb_reg       <= evict & take_dirty;
            victim_reg   <= evict ? take_tag : '0;
            last_reg     <= last_blk;
            req_miss_reg <= miss_wide[MISS_W-1:0];
            tot_hit_reg  <= hit_cnt_next;
            tot_miss_reg <= miss_cnt_next;
            tot_repl_reg <= repl_cnt_next;
        end
    end

    assign res_valid          = res_valid_reg;
    assign block_address      = blk_out_reg;
    assign hit                = hit_reg;
    assign slot               = slot_reg;
    assign replaced           = repl_reg;
    assign writeback_needed   = wb_reg;
    assign victim_block       = victim_reg;
    assign last               = last_reg;
    assign request_misses     = req_miss_reg;
    assign total_hits         = tot_hit_reg;
    assign total_misses       = tot_miss_reg;
    assign total_replacements = tot_repl_reg;

    // -------------------------------------------------------------------------
    // assertions
    // -------------------------------------------------------------------------

    // at most one entry in use holds the insert token
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({tok_vec, ~(|tok_vec)}) || $onehot(tok_vec))
        else $error("insert token lost or duplicated");

    // an update always leaves a result beat behind
    a_fire_beat: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("update without result beat");

    // a miss beat carries a nonzero miss count for its request
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !hit_reg) |-> (req_miss_reg != '0 || RW > MISS_W))
        else $error("miss beat with zero request misses");

    // writeback only on an eviction, and never on a hit
    a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((!wb_reg || repl_reg) && !(hit_reg && repl_reg)))
        else $error("writeback or eviction flags inconsistent");

    // the last block of a run returns the sequencer to idle
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_blk) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not finish the run");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fifo replacement block cache: a cycle-free
// model of the cache predicts every per-block result when a request beat is
// accepted, and a monitor compares each result beat field by field
// ----------------------------------------------------------------------------
module testbench;
    import fbc_pkg::*;

    // bench timing
    localparam int SETTLE_CYCLES = 12;       // quiet cycles before a config write
    localparam int DRAIN_LIMIT   = 50000;    // cycles to wait for outstanding results
    localparam int RUN_LIMIT     = 5000000;  // hard stop for the whole run

    // one expected result beat
    typedef struct packed {
        logic [TAG_W-1:0]  block_address;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              replaced;
        logic              writeback_needed;
        logic [TAG_W-1:0]  victim_block;
        logic              last;
        logic [MISS_W-1:0] request_misses;
        logic [CNT_W-1:0]  total_hits;
        logic [CNT_W-1:0]  total_misses;
        logic [CNT_W-1:0]  total_replacements;
    } block_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [CFG_W-1:0]  cfg_write_data;
    logic              req_valid;
    logic              req_stall;
    logic [TAG_W-1:0]  start_block;
    logic [RUN_W-1:0]  run_length;
    logic              kind;
    logic              res_valid;
    logic              res_stall;
    logic [TAG_W-1:0]  block_address;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
    logic              writeback_needed;
    logic [TAG_W-1:0]  victim_block;
    logic              last;
    logic [MISS_W-1:0] request_misses;
    logic [CNT_W-1:0]  total_hits;
    logic [CNT_W-1:0]  total_misses;
    logic [CNT_W-1:0]  total_replacements;

    // shadow copy of the cache contents and totals
    logic [TAG_W-1:0]  line_tag   [ENTRIES_DEF];
    bit                line_valid [ENTRIES_DEF];
    bit                line_dirty [ENTRIES_DEF];
    int unsigned       fill_ptr;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  replace_total;
    logic [CFG_W-1:0]  entries_cfg;

    // results predicted but not yet seen, oldest first
    block_result_t     awaited_results[$];

    int                errors;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_off_left;

    fifo_replacement_block_cache dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .start_block        (start_block),
        .run_length         (run_length),
        .kind               (kind),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .block_address      (block_address),
        .hit                (hit),
        .slot               (slot),
        .replaced           (replaced),
        .writeback_needed   (writeback_needed),
        .victim_block       (victim_block),
        .last               (last),
        .request_misses     (request_misses),
        .total_hits         (total_hits),
        .total_misses       (total_misses),
        .total_replacements (total_replacements)
    );

    // 12 unit clock period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // cache model
    // ------------------------------------------------------------------

    // walk the run block by block and queue the result each block gives
    task automatic predict_access(input logic [TAG_W-1:0] first_blk,
                                  input logic [RUN_W-1:0] len_in,
                                  input logic rw);
        int unsigned       n_use;
        int unsigned       run;
        int unsigned       k;
        int unsigned       i;
        int unsigned       pos;
        bit                found;
        logic [TAG_W-1:0]  blk;
        logic [MISS_W-1:0] misses;
        block_result_t     r;

        // register value out of range is pulled back to 1..ENTRIES
        n_use = 32'(entries_cfg);
        if (n_use == 0)
            n_use = 1;
        if (n_use > ENTRIES_DEF)
            n_use = ENTRIES_DEF;
        run = 32'(len_in);
        if (run > MAX_RUN_DEF)
            run = MAX_RUN_DEF;
        misses = '0;

        for (k = 0; k < run; k++)
        begin
            blk   = first_blk + TAG_W'(k);   // wraps modulo 2^32
            found = 1'b0;
            pos   = 0;
            r     = '0;

            // lowest matching entry among those in use wins
            for (i = 0; i < n_use && !found; i++)
            begin
                if (line_valid[i] && line_tag[i] == blk)
                begin
                    pos   = i;
                    found = 1'b1;
                end
            end

            if (found)
            begin
                if (!(&hit_total))
                    hit_total++;
                if (rw == KIND_WRITE)
                    line_dirty[pos] = 1'b1;
            end
            else
            begin
                // pointer past the entries in use restarts at entry 0
                pos      = (fill_ptr < n_use) ? fill_ptr : 0;
                fill_ptr = (pos + 1 >= n_use) ? 0 : pos + 1;
                if (line_valid[pos])
                begin
                    r.replaced         = 1'b1;
                    r.writeback_needed = line_dirty[pos];
                    r.victim_block     = line_tag[pos];
                    if (!(&replace_total))
                        replace_total++;
                end
                line_tag[pos]   = blk;
                line_valid[pos] = 1'b1;
                line_dirty[pos] = (rw == KIND_WRITE);
                misses++;
                if (!(&miss_total))
                    miss_total++;
            end

            r.block_address      = blk;
            r.hit                = found;
            r.slot               = SLOT_W'(pos);
            r.last               = (k + 1 == run);
            r.request_misses     = misses;
            r.total_hits         = hit_total;
            r.total_misses       = miss_total;
            r.total_replacements = replace_total;
            awaited_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // entered and left at a falling edge; valid stays high on return so a
    // following beat can go out back to back
    task automatic send_request(input logic [TAG_W-1:0] first_blk,
                                input logic [RUN_W-1:0] len_in,
                                input logic rw);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        start_block <= first_blk;
        run_length  <= len_in;
        kind        <= rw;
        do
            @(posedge clk);
        while (req_stall);
        predict_access(first_blk, len_in, rw);
        @(negedge clk);
    endtask

    // drop valid, let every predicted result come home, then let the
    // pipeline run dry (a zero length run leaves nothing to wait for)
    task automatic wait_for_idle();
        int guard;

        guard = 0;
        req_valid <= 1'b0;
        while (awaited_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write only while the block is quiet
    task automatic set_entries_in_use(input logic [CFG_W-1:0] value);
        wait_for_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        entries_cfg = value;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // stall driver: a long hold-off counts down here, otherwise random
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                res_stall <= 1'b1;
                hold_off_left--;
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // every accepted result beat is matched against the oldest prediction
    always @(posedge clk)
    begin : check_results
        block_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual block %h",
                         $time, block_address);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("block_address", want.block_address, block_address);
                compare_field("hit", want.hit, hit);
                compare_field("slot", want.slot, slot);
                compare_field("replaced", want.replaced, replaced);
                compare_field("writeback_needed", want.writeback_needed, writeback_needed);
                compare_field("victim_block", want.victim_block, victim_block);
                compare_field("last", want.last, last);
                compare_field("request_misses", want.request_misses, request_misses);
                compare_field("total_hits", want.total_hits, total_hits);
                compare_field("total_misses", want.total_misses, total_misses);
                compare_field("total_replacements", want.total_replacements,
                              total_replacements);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset geometry of 64 entries: fill, write hit, wrap past the top
    task automatic test_default_geometry();
        send_request(32'h0000_0000, 5'd1, KIND_READ);
        send_request(32'h0000_0000, 5'd1, KIND_WRITE);   // hit marks dirty
        send_request(32'hFFFF_FFFE, 5'd4, KIND_READ);    // wraps to 0 and 1
        send_request(32'h8000_0000, 5'd16, KIND_WRITE);
    endtask

    // zero length runs and runs above the limit
    task automatic test_run_lengths();
        send_request(32'h1234_5678, 5'd0, KIND_READ);    // no result at all
        send_request(32'h8000_0008, 5'd31, KIND_READ);   // clamped to 16
        send_request(32'h8000_0000, 5'd17, KIND_WRITE);  // clamped to 16
        send_request(32'h7FFF_FFFF, 5'd0, KIND_WRITE);
    endtask

    // one entry in use: every miss evicts, dirty victims need writeback;
    // the insert pointer sits past the one entry and restarts at 0
    task automatic test_single_entry();
        set_entries_in_use(7'd1);
        send_request(32'hDEAD_BEEF, 5'd1, KIND_WRITE);
        send_request(32'hDEAD_BEEF, 5'd1, KIND_READ);
        send_request(32'hCAFE_F00D, 5'd3, KIND_READ);
        set_entries_in_use(7'd0);                        // counts as one entry
        send_request(32'hFFFF_FFFF, 5'd1, KIND_WRITE);   // duplicate of an outer entry
    endtask

    // grow back to all entries: hidden contents reappear, duplicate tags
    // resolve to the lowest entry, then a fill sweeps over mixed victims
    task automatic test_lowest_match();
        set_entries_in_use(7'h7F);                       // above range, all entries
        send_request(32'hFFFF_FFFF, 5'd1, KIND_READ);
        send_request(32'hFFFF_FFFE, 5'd2, KIND_READ);
        send_request(32'h5555_0000, 5'd16, KIND_READ);
    endtask

    // two entries ping-pong, then a value just above range
    task automatic test_small_geometry();
        set_entries_in_use(7'd2);
        send_request(32'h0000_00A0, 5'd5, KIND_WRITE);
        send_request(32'h0000_00A3, 5'd2, KIND_READ);
        set_entries_in_use(7'd65);
        send_request(32'h0000_00A0, 5'd5, KIND_READ);
    endtask

    // receiver holds off while the sender keeps offering beats, so the
    // result path backs up into the request input
    task automatic test_backpressure();
        int j;

        set_entries_in_use(7'd8);
        send_idle_pct = 0;
        hold_off_left = 300;
        for (j = 0; j < 24; j++)
            send_request(32'h0000_4000 + TAG_W'($urandom_range(0, 24)),
                         RUN_W'($urandom_range(4, 16)), logic'($urandom_range(0, 1)));
        wait_for_idle();
    endtask

    // random requests, mostly clustered around a base so that hits,
    // evictions and dirty victims all show up; two geometries per call
    task automatic test_random_traffic(input int items, input int snd_pct,
                                       input int rcv_pct,
                                       input logic [CFG_W-1:0] cfg_a,
                                       input logic [CFG_W-1:0] cfg_b);
        int               done;
        int               pick;
        int unsigned      span;
        logic [TAG_W-1:0] hot_base;
        logic [TAG_W-1:0] blk;
        logic [RUN_W-1:0] len;

        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        set_entries_in_use(cfg_a);
        done = 0;
        while (done < items)
        begin
            if (done == items / 2)
                set_entries_in_use(cfg_b);
            // new hot region now and then, sometimes at the top of the space
            if (done % 30 == 0)
                hot_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF4 : $urandom;
            span = (entries_cfg == 0) ? 4 : 2 * entries_cfg + 4;
            pick = $urandom_range(0, 99);
            blk  = hot_base + TAG_W'($urandom_range(0, span));
            if (pick < 65)
                len = RUN_W'($urandom_range(1, 6));
            else if (pick < 80)
                len = RUN_W'($urandom_range(7, 16));
            else if (pick < 92)
            begin
                blk = $urandom;
                len = RUN_W'($urandom_range(1, 16));
            end
            else if (pick < 97)
                len = RUN_W'($urandom_range(17, 31));    // clamped run
            else
                len = '0;                                // ignored, not counted
            send_request(blk, len, logic'($urandom_range(0, 1)));
            if (len != 0)
                done++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        req_valid      = 1'b0;
        start_block    = '0;
        run_length     = '0;
        kind           = KIND_READ;
        errors         = 0;
        hold_off_left  = 0;
        send_idle_pct  = 30;
        recv_idle_pct  = 48;

        // model matches the cleared state after reset
        for (int e = 0; e < ENTRIES_DEF; e++)
        begin
            line_tag[e]   = '0;
            line_valid[e] = 1'b0;
            line_dirty[e] = 1'b0;
        end
        fill_ptr      = 0;
        hit_total     = '0;
        miss_total    = '0;
        replace_total = '0;
        entries_cfg   = CFG_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_geometry();
        test_run_lengths();
        test_single_entry();
        test_lowest_match();
        test_small_geometry();
        test_backpressure();
        test_random_traffic(105, 30, 48, 7'd64, 7'd3);
        test_random_traffic(105, 48, 30, 7'd16, 7'd1);
        test_random_traffic(105, 0, 0, 7'd37, 7'd64);

        wait_for_idle();
        if (awaited_results.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     awaited_results.size());
        if (errors == 0 && awaited_results.size() == 0)
            $display("fifo_replacement_block_cache test passed");
        else
            $display("fifo_replacement_block_cache test failed");
        $finish;
    end

    // hard stop if the handshake hangs
    initial
    begin
        #RUN_LIMIT;
        $display("fifo_replacement_block_cache test failed");
        $finish;
    end

endmodule
